FILE: rtl/dfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants, result type and the CRC16 byte update for the deframer.
// ----------------------------------------------------------------------------
package dfr_pkg;

  // hard upper bound on the payload length
  localparam int unsigned MAX_PAYLOAD = 1024;
  // field counter width: must hold the largest payload length and count to 8
  localparam int unsigned CNT_W =
    ($clog2(MAX_PAYLOAD + 1) > 4) ? $clog2(MAX_PAYLOAD + 1) : 4;

  // configuration port
  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_MAX_PAYLOAD_ADDR = 2'h0;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;

  // magic bytes 'l' 's' 'p' 'h'
  localparam logic [7:0] MAGIC_0 = 8'h6C;
  localparam logic [7:0] MAGIC_1 = 8'h73;
  localparam logic [7:0] MAGIC_2 = 8'h70;
  localparam logic [7:0] MAGIC_3 = 8'h68;

  // crc16 modbus form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_BAD_CRC  = 2'd2;
  localparam logic [1:0] KIND_TOO_LONG = 2'd3;

  // one result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [63:0] frame_index;
    logic [15:0] command;
    logic [7:0]  error_code;
    logic [15:0] payload_length;
    logic        last;
  } dfr_res_t;

  // reflected crc16, one byte, bit at a time
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/dfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_rx_if / dfr_res_if
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
interface dfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [63:0] frame_index;
  logic [15:0] command;
  logic [7:0]  error_code;
  logic [15:0] payload_length;
  logic        last;

  modport source (
    output valid, output kind, output payload_byte, output frame_index,
    output command, output error_code, output payload_length, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input frame_index,
    input command, input error_code, input payload_length, input last,
    output ready
  );
endinterface

FILE: rtl/dfr_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_apb_regs
// APB register slice holding the max_payload limit.
// ----------------------------------------------------------------------------
module dfr_apb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dfr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [dfr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [dfr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [15:0]                      max_payload_o
);

  logic [15:0] max_payload_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == dfr_pkg::REG_MAX_PAYLOAD_ADDR);

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= dfr_pkg::MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      max_payload_q <= pwdata[15:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == dfr_pkg::REG_MAX_PAYLOAD_ADDR) begin
      prdata = {{(dfr_pkg::APB_DATA_W-16){1'b0}}, max_payload_q};
    end
  end

  assign max_payload_o = max_payload_q;

endmodule

FILE: rtl/dfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_parser
// Frame state, header fields and running CRC; one byte per step.
// ----------------------------------------------------------------------------
module dfr_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic [15:0]       max_payload_i,
  output logic              res_valid_o,
  output dfr_pkg::dfr_res_t res_o
);

  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_MAG1   = 4'd1;
  localparam logic [3:0] PH_MAG2   = 4'd2;
  localparam logic [3:0] PH_MAG3   = 4'd3;
  localparam logic [3:0] PH_INDEX  = 4'd4;
  localparam logic [3:0] PH_CMD    = 4'd5;
  localparam logic [3:0] PH_ERR    = 4'd6;
  localparam logic [3:0] PH_LEN    = 4'd7;
  localparam logic [3:0] PH_DATA   = 4'd8;
  localparam logic [3:0] PH_CHK_HI = 4'd9;
  localparam logic [3:0] PH_CHK_LO = 4'd10;

  localparam int unsigned CW = dfr_pkg::CNT_W;

  logic [3:0]    phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [15:0]   crc_q, crc_d, crc_step, crc_start;
  logic [63:0]   index_q, index_d;
  logic [15:0]   cmd_q, cmd_d;
  logic [7:0]    err_q, err_d;
  logic [31:0]   len_q, len_d, len_shift;
  logic [7:0]    chk_hi_q, chk_hi_d;
  logic [15:0]   limit;
  logic [7:0]    want;

  assign crc_step  = dfr_pkg::crc16_byte(crc_q, byte_i);
  assign crc_start = dfr_pkg::crc16_byte(dfr_pkg::CRC_INIT, byte_i);
  assign cnt_inc   = cnt_q + CW'(1);
  assign len_shift = {len_q[23:0], byte_i};
  assign limit     = (max_payload_i > 16'(dfr_pkg::MAX_PAYLOAD)) ?
                     16'(dfr_pkg::MAX_PAYLOAD) : max_payload_i;

  // expected magic byte in the match phases
  always_comb begin
    case (phase_q)
      PH_MAG1: want = dfr_pkg::MAGIC_1;
      PH_MAG2: want = dfr_pkg::MAGIC_2;
      default: want = dfr_pkg::MAGIC_3;
    endcase
  end

  // next state and result for the byte at hand
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    index_d  = index_q;
    cmd_d    = cmd_q;
    err_d    = err_q;
    len_d    = len_q;
    chk_hi_d = chk_hi_q;
    res_valid_o        = 1'b0;
    res_o.kind         = dfr_pkg::KIND_PAYLOAD;
    res_o.payload_byte = 8'h00;
    res_o.last         = 1'b0;

    case (phase_q)
      PH_MAG1, PH_MAG2, PH_MAG3: begin
        if (byte_i != want) begin
          // broken match: restart, possibly on this byte
          if (byte_i == dfr_pkg::MAGIC_0) begin
            crc_d   = crc_start;
            phase_d = PH_MAG1;
          end else begin
            crc_d   = dfr_pkg::CRC_INIT;
            phase_d = PH_HUNT;
          end
        end else begin
          crc_d = crc_step;
          if (phase_q == PH_MAG3) begin
            phase_d = PH_INDEX;
            cnt_d   = '0;
            index_d = '0;
            cmd_d   = '0;
            err_d   = '0;
            len_d   = '0;
          end else begin
            phase_d = phase_q + 4'd1;
          end
        end
      end
      PH_INDEX: begin
        crc_d   = crc_step;
        index_d = {index_q[55:0], byte_i};
        cnt_d   = cnt_inc;
        if (cnt_q == CW'(7)) begin
          cnt_d   = '0;
          phase_d = PH_CMD;
        end
      end
      PH_CMD: begin
        crc_d = crc_step;
        cmd_d = {cmd_q[7:0], byte_i};
        cnt_d = cnt_inc;
        if (cnt_q == CW'(1)) begin
          cnt_d   = '0;
          phase_d = PH_ERR;
        end
      end
      PH_ERR: begin
        crc_d   = crc_step;
        err_d   = byte_i;
        cnt_d   = '0;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        crc_d = crc_step;
        len_d = len_shift;
        cnt_d = cnt_inc;
        if (cnt_q == CW'(3)) begin
          cnt_d = '0;
          if (len_shift > {16'h0000, limit}) begin
            res_valid_o = 1'b1;
            res_o.kind  = dfr_pkg::KIND_TOO_LONG;
            res_o.last  = 1'b1;
            phase_d     = PH_HUNT;
            crc_d       = dfr_pkg::CRC_INIT;
          end else if (len_shift == 32'h0) begin
            phase_d = PH_CHK_HI;
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        crc_d              = crc_step;
        res_valid_o        = 1'b1;
        res_o.payload_byte = byte_i;
        cnt_d              = cnt_inc;
        if ({{(32-CW){1'b0}}, cnt_inc} >= len_q) begin
          cnt_d   = '0;
          phase_d = PH_CHK_HI;
        end
      end
      PH_CHK_HI: begin
        chk_hi_d = byte_i;
        phase_d  = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        res_valid_o = 1'b1;
        res_o.kind  = ({chk_hi_q, byte_i} == crc_q) ? dfr_pkg::KIND_GOOD :
                                                      dfr_pkg::KIND_BAD_CRC;
        res_o.last  = 1'b1;
        phase_d     = PH_HUNT;
        crc_d       = dfr_pkg::CRC_INIT;
        cnt_d       = '0;
      end
      default: begin
        // hunting, and codes that mean nothing
        if (byte_i == dfr_pkg::MAGIC_0) begin
          crc_d   = crc_start;
          phase_d = PH_MAG1;
        end else begin
          crc_d   = dfr_pkg::CRC_INIT;
          phase_d = PH_HUNT;
        end
      end
    endcase

    res_o.frame_index    = index_d;
    res_o.command        = cmd_d;
    res_o.error_code     = err_d;
    res_o.payload_length = (len_d > 32'h0000_FFFF) ? 16'hFFFF : len_d[15:0];
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      cnt_q    <= '0;
      crc_q    <= dfr_pkg::CRC_INIT;
      index_q  <= '0;
      cmd_q    <= '0;
      err_q    <= '0;
      len_q    <= '0;
      chk_hi_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      index_q  <= index_d;
      cmd_q    <= cmd_d;
      err_q    <= err_d;
      len_q    <= len_d;
      chk_hi_q <= chk_hi_d;
    end
  end

endmodule

FILE: rtl/dfr_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_out_stage
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module dfr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  dfr_pkg::dfr_res_t res_i,
  output logic              can_take_o,
  dfr_res_if.source         res_o
);

  logic              valid_q;
  dfr_pkg::dfr_res_t res_q;

  // slot is free when empty or draining this cycle
  assign can_take_o = !valid_q || res_o.ready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_take_o) begin
      valid_q <= load_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i && can_take_o) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid          = valid_q;
  assign res_o.kind           = res_q.kind;
  assign res_o.payload_byte   = res_q.payload_byte;
  assign res_o.frame_index    = res_q.frame_index;
  assign res_o.command        = res_q.command;
  assign res_o.error_code     = res_q.error_code;
  assign res_o.payload_length = res_q.payload_length;
  assign res_o.last           = res_q.last;

endmodule

FILE: rtl/crc16_checked_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_checked_frame_deframer
// Byte-stream deframer: magic, header, payload, CRC16 (Modbus) check.
// ----------------------------------------------------------------------------
// The block takes one received byte per beat and sustains one byte per clock
// while the output is not stalled. A byte is held in an input register, then
// the frame step (magic match, header shift, length check, CRC16 byte update)
// runs combinationally into the result register; the eight-bit CRC update sets
// the clock period. Each result passes the input register, then the result
// register. While a result waits at the output and is not taken, the held
// byte waits as well and the input is not ready; bytes that make no result
// (magic, most header bytes, high check byte) pass without an output beat.
// Each payload byte gives one beat of kind 0; a frame ends with one beat of
// kind 1 (good), 2 (check mismatch) or 3 (length above the limit, which is the
// lower of max_payload and 1024), each with last set and the header fields.
// ----------------------------------------------------------------------------
module crc16_checked_frame_deframer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dfr_rx_if.sink                         rx_i,
  dfr_res_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dfr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dfr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dfr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              can_take;
  logic              step;
  logic [15:0]       max_payload;
  logic              res_valid;
  dfr_pkg::dfr_res_t res;

  // configuration registers
  dfr_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_payload_o (max_payload)
  );

  // held byte moves on when the result slot can take its outcome
  assign step     = in_valid_q && can_take;
  assign rx_i.ready = !in_valid_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // frame parser
  dfr_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .byte_i        (in_byte_q),
    .max_payload_i (max_payload),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // result register
  dfr_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && res_valid),
    .res_i      (res),
    .can_take_o (can_take),
    .res_o      (res_o)
  );

endmodule

FILE: verif/dfr_deframe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_deframe_checker
// Passive checker for the CRC16 frame deframer. It follows every accepted
// byte through its own copy of the frame parser, keeps the result beats that
// must come out in order, and compares each accepted result beat field by
// field. It also follows writes on the config port to track max_payload.
// ----------------------------------------------------------------------------
module dfr_deframe_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dfr_rx_if                              rx_i,
  dfr_res_if                             res_i,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic                           pready_i,
  input  logic [dfr_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [dfr_pkg::APB_DATA_W-1:0] pwdata_i,
  output int                             pending_o,
  output int                             errors_o,
  output int                             beats_o,
  output int                             good_o,
  output int                             bad_o,
  output int                             long_o
);

  typedef enum logic [3:0] {
    PH_HUNT, PH_MAG1, PH_MAG2, PH_MAG3, PH_INDEX, PH_CMD, PH_ERR, PH_LEN,
    PH_DATA, PH_CHK_HI, PH_CHK_LO
  } deframe_phase_e;

  localparam int MAX_REPORTS = 40;

  // parser state
  deframe_phase_e phase_q;
  logic [15:0]    field_cnt;
  logic [15:0]    frame_crc;
  logic [63:0]    index_q;
  logic [15:0]    cmd_q;
  logic [7:0]     err_q;
  logic [31:0]    length_q;
  logic [7:0]     check_hi_q;
  logic [15:0]    max_payload_q;

  // result beats still to come, oldest first
  dfr_pkg::dfr_res_t expected_beats[$];

  int mismatches;
  int beats_seen;
  int good_seen;
  int bad_seen;
  int long_seen;

  // crc16 modbus update over one byte, lsb first
  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc ^ {8'h00, d};
    repeat (8) begin
      r = r[0] ? ((r >> 1) ^ dfr_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // result beat carrying the current header fields
  function automatic dfr_pkg::dfr_res_t frame_beat(input logic [1:0] kind,
                                                   input logic [7:0] data,
                                                   input logic is_last);
    dfr_pkg::dfr_res_t r;
    r.kind           = kind;
    r.payload_byte   = data;
    r.frame_index    = index_q;
    r.command        = cmd_q;
    r.error_code     = err_q;
    r.payload_length = (length_q > 32'h0000_FFFF) ? 16'hFFFF : length_q[15:0];
    r.last           = is_last;
    return r;
  endfunction

  // look for the first magic byte, the breaking byte may start a new match
  task automatic restart_hunt(input logic [7:0] b);
    frame_crc = dfr_pkg::CRC_INIT;
    phase_q   = PH_HUNT;
    if (b == dfr_pkg::MAGIC_0) begin
      frame_crc = crc16_next(dfr_pkg::CRC_INIT, b);
      phase_q   = PH_MAG1;
    end
  endtask

  // advance the parser by one byte and queue any result it causes
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0]  want_magic;
    logic [31:0] limit;
    logic [15:0] rx_check;
    case (phase_q)
      PH_MAG1, PH_MAG2, PH_MAG3: begin
        want_magic = (phase_q == PH_MAG1) ? dfr_pkg::MAGIC_1 :
                     (phase_q == PH_MAG2) ? dfr_pkg::MAGIC_2 : dfr_pkg::MAGIC_3;
        if (b != want_magic) begin
          restart_hunt(b);
        end else begin
          frame_crc = crc16_next(frame_crc, b);
          if (phase_q == PH_MAG3) begin
            phase_q   = PH_INDEX;
            field_cnt = '0;
            index_q   = '0;
            cmd_q     = '0;
            err_q     = '0;
            length_q  = '0;
          end else begin
            phase_q = (phase_q == PH_MAG1) ? PH_MAG2 : PH_MAG3;
          end
        end
      end
      PH_INDEX: begin
        frame_crc = crc16_next(frame_crc, b);
        index_q   = {index_q[55:0], b};
        field_cnt++;
        if (field_cnt >= 16'd8) begin
          field_cnt = '0;
          phase_q   = PH_CMD;
        end
      end
      PH_CMD: begin
        frame_crc = crc16_next(frame_crc, b);
        cmd_q     = {cmd_q[7:0], b};
        field_cnt++;
        if (field_cnt >= 16'd2) begin
          field_cnt = '0;
          phase_q   = PH_ERR;
        end
      end
      PH_ERR: begin
        frame_crc = crc16_next(frame_crc, b);
        err_q     = b;
        field_cnt = '0;
        phase_q   = PH_LEN;
      end
      PH_LEN: begin
        frame_crc = crc16_next(frame_crc, b);
        length_q  = {length_q[23:0], b};
        field_cnt++;
        if (field_cnt >= 16'd4) begin
          field_cnt = '0;
          // effective limit is the lower of the register and the hard bound
          limit = (max_payload_q < dfr_pkg::MAX_PAYLOAD) ? {16'h0000, max_payload_q} :
                                                           dfr_pkg::MAX_PAYLOAD;
          if (length_q > limit) begin
            expected_beats.push_back(frame_beat(dfr_pkg::KIND_TOO_LONG, 8'h00, 1'b1));
            phase_q   = PH_HUNT;
            frame_crc = dfr_pkg::CRC_INIT;
          end else begin
            phase_q = (length_q == 32'd0) ? PH_CHK_HI : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        frame_crc = crc16_next(frame_crc, b);
        expected_beats.push_back(frame_beat(dfr_pkg::KIND_PAYLOAD, b, 1'b0));
        field_cnt++;
        if ({16'h0000, field_cnt} >= length_q) begin
          field_cnt = '0;
          phase_q   = PH_CHK_HI;
        end
      end
      PH_CHK_HI: begin
        check_hi_q = b;
        phase_q    = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        rx_check = {check_hi_q, b};
        expected_beats.push_back(frame_beat((rx_check == frame_crc) ? dfr_pkg::KIND_GOOD :
                                                                      dfr_pkg::KIND_BAD_CRC,
                                            8'h00, 1'b1));
        phase_q   = PH_HUNT;
        frame_crc = dfr_pkg::CRC_INIT;
        field_cnt = '0;
      end
      default: begin
        restart_hunt(b);
      end
    endcase
  endtask

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  // compare one accepted result beat with the oldest expected one
  task automatic check_beat();
    dfr_pkg::dfr_res_t got;
    dfr_pkg::dfr_res_t want;
    got = {res_i.kind, res_i.payload_byte, res_i.frame_index, res_i.command,
           res_i.error_code, res_i.payload_length, res_i.last};
    if (expected_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: unexpected result beat, expected none, actual kind %0d",
                 $time, got.kind);
      end
      return;
    end
    want = expected_beats.pop_front();
    beats_seen++;
    case (want.kind)
      dfr_pkg::KIND_GOOD:     good_seen++;
      dfr_pkg::KIND_BAD_CRC:  bad_seen++;
      dfr_pkg::KIND_TOO_LONG: long_seen++;
      default: ;
    endcase
    if (got.kind !== want.kind) report_field("kind", want.kind, got.kind);
    if (got.payload_byte !== want.payload_byte) begin
      report_field("payload_byte", want.payload_byte, got.payload_byte);
    end
    if (got.frame_index !== want.frame_index) begin
      report_field("frame_index", want.frame_index, got.frame_index);
    end
    if (got.command !== want.command) report_field("command", want.command, got.command);
    if (got.error_code !== want.error_code) begin
      report_field("error_code", want.error_code, got.error_code);
    end
    if (got.payload_length !== want.payload_length) begin
      report_field("payload_length", want.payload_length, got.payload_length);
    end
    if (got.last !== want.last) report_field("last", want.last, got.last);
  endtask

  // results first, then config, then the new byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       = PH_HUNT;
      field_cnt     = '0;
      frame_crc     = dfr_pkg::CRC_INIT;
      index_q       = '0;
      cmd_q         = '0;
      err_q         = '0;
      length_q      = '0;
      check_hi_q    = '0;
      max_payload_q = dfr_pkg::MAX_PAYLOAD_RESET;
      expected_beats.delete();
      mismatches    = 0;
      beats_seen    = 0;
      good_seen     = 0;
      bad_seen      = 0;
      long_seen     = 0;
      pending_o    <= 0;
      errors_o     <= 0;
      beats_o      <= 0;
      good_o       <= 0;
      bad_o        <= 0;
      long_o       <= 0;
    end else begin
      if (res_i.valid && res_i.ready) check_beat();
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == dfr_pkg::REG_MAX_PAYLOAD_ADDR) begin
        max_payload_q = pwdata_i[15:0];
      end
      if (rx_i.valid && rx_i.ready) deframe_byte(rx_i.rx_byte);
      pending_o <= expected_beats.size();
      errors_o  <= mismatches;
      beats_o   <= beats_seen;
      good_o    <= good_seen;
      bad_o     <= bad_seen;
      long_o    <= long_seen;
    end
  end

endmodule

FILE: verif/crc16_checked_frame_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_checked_frame_deframer_test
// Byte stream stimulus for the CRC16 frame deframer: magic hunting, good and
// corrupted frames, oversized and truncated frames and line noise, under a
// range of max_payload settings, with bursty input and a stalling receiver.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module crc16_checked_frame_deframer_test;

  localparam int RAND_BYTES_PER_SETTING = 300;
  localparam int IDLE_LIMIT             = 1000;
  localparam int SETTLE_CYCLES          = 8;
  localparam int NUM_SETTINGS           = 7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [dfr_pkg::APB_ADDR_W-1:0] paddr;
  logic [dfr_pkg::APB_DATA_W-1:0] pwdata;
  logic [dfr_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  int pending_beats;
  int mismatch_cnt;
  int beats_cnt;
  int good_cnt;
  int bad_cnt;
  int long_cnt;

  dfr_rx_if  rx ();
  dfr_res_if res ();

  // bytes waiting to be sent
  logic [7:0]  tx_bytes[$];
  logic [15:0] cur_max = dfr_pkg::MAX_PAYLOAD_RESET;
  bit          gaps_on;
  bit          stalls_on;
  int          burst_left;
  int          bytes_sent;
  int          idle_cycles;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  crc16_checked_frame_deframer u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dfr_deframe_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx),
    .res_i     (res),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .pready_i  (pready),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .pending_o (pending_beats),
    .errors_o  (mismatch_cnt),
    .beats_o   (beats_cnt),
    .good_o    (good_cnt),
    .bad_o     (bad_cnt),
    .long_o    (long_cnt)
  );

  // crc16 modbus, used to close the frames we build
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      r = {1'b0, r[15:1]} ^ (r[0] ? dfr_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // header, optional payload and check bytes appended to the send queue
  task automatic queue_frame(input logic [63:0] idx, input logic [15:0] cmd,
                             input logic [7:0] err, input logic [31:0] len,
                             input bit with_body, input bit corrupt);
    logic [7:0]  head[19];
    logic [15:0] crc;
    logic [7:0]  b;
    head = '{dfr_pkg::MAGIC_0, dfr_pkg::MAGIC_1, dfr_pkg::MAGIC_2, dfr_pkg::MAGIC_3,
             idx[63:56], idx[55:48], idx[47:40], idx[39:32],
             idx[31:24], idx[23:16], idx[15:8], idx[7:0],
             cmd[15:8], cmd[7:0], err,
             len[31:24], len[23:16], len[15:8], len[7:0]};
    crc = dfr_pkg::CRC_INIT;
    foreach (head[i]) begin
      tx_bytes.push_back(head[i]);
      crc = crc_step(crc, head[i]);
    end
    if (with_body) begin
      for (int unsigned i = 0; i < len; i++) begin
        b = 8'($urandom);
        tx_bytes.push_back(b);
        crc = crc_step(crc, b);
      end
      if (corrupt) crc = crc ^ 16'($urandom_range(1, 65535));
      tx_bytes.push_back(crc[15:8]);
      tx_bytes.push_back(crc[7:0]);
    end
  endtask

  // frame with random header fields, now and then all zeros or all ones
  task automatic queue_random_frame(input logic [31:0] len, input bit with_body,
                                    input bit corrupt);
    logic [63:0] idx;
    logic [15:0] cmd;
    logic [7:0]  err;
    idx = {$urandom, $urandom};
    cmd = 16'($urandom);
    err = 8'($urandom);
    case ($urandom_range(0, 7))
      0: begin
        idx = '0;
        cmd = '0;
        err = '0;
      end
      1: begin
        idx = '1;
        cmd = '1;
        err = '1;
      end
      default: ;
    endcase
    queue_frame(idx, cmd, err, len, with_body, corrupt);
  endtask

  // one beat on the byte channel, bursts separated by random gaps
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        rx.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (!rx.ready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  // hold the sender until every result is out and the pipe is quiet
  task automatic drain_results();
    rx.valid <= 1'b0;
    do @(posedge clk_i); while (pending_beats != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side stalls in random stretches when stalls are on
  initial begin : result_sink
    int   hold;
    logic level;
    res.ready <= 1'b0;
    forever begin
      hold  = $urandom_range(1, 24);
      level = !stalls_on || ($urandom_range(0, 2) != 0);
      repeat (hold) begin
        @(posedge clk_i);
        res.ready <= level;
      end
    end
  end

  // watchdog: no beat on either channel for too long
  always @(posedge clk_i) begin
    if ((rx.valid && rx.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0]  magic_noise[18];
    logic [15:0] settings[NUM_SETTINGS];
    logic [31:0] lim;
    logic [31:0] len;
    logic [31:0] small_len;
    int          target;
    int          pick;
    int          n;

    magic_noise = '{8'h00, 8'hFF, dfr_pkg::MAGIC_0, 8'hFF, dfr_pkg::MAGIC_0,
                    dfr_pkg::MAGIC_1, 8'h00, dfr_pkg::MAGIC_0, dfr_pkg::MAGIC_1,
                    dfr_pkg::MAGIC_0, dfr_pkg::MAGIC_1, dfr_pkg::MAGIC_2, 8'h00,
                    dfr_pkg::MAGIC_0, dfr_pkg::MAGIC_0, dfr_pkg::MAGIC_1,
                    dfr_pkg::MAGIC_2, dfr_pkg::MAGIC_0};

    rx.valid   <= 1'b0;
    rx.rx_byte <= 8'h00;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;

    settings    = '{16'd0, 16'd1, 16'hFFFF, 16'd1024, 16'd1023, 16'd0, 16'd256};
    settings[5] = 16'($urandom_range(2, 200));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: magic broken at every position, all kinds, field extremes
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    foreach (magic_noise[i]) tx_bytes.push_back(magic_noise[i]);
    queue_frame(64'h0, 16'h0000, 8'h00, 32'd0, 1'b1, 1'b0);
    queue_frame('1, 16'hFFFF, 8'hFF, 32'd1, 1'b1, 1'b0);
    queue_random_frame(32'd3, 1'b1, 1'b1);
    queue_random_frame(32'd257, 1'b0, 1'b0);
    queue_random_frame(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_queued();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      gaps_on   = (s != 0) && ($urandom_range(0, 3) != 0);
      stalls_on = (s != 0) && ($urandom_range(0, 3) != 0);

      // new max_payload, written only once the block is idle
      drain_results();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= dfr_pkg::REG_MAX_PAYLOAD_ADDR;
      pwdata  <= {16'($urandom), settings[s]};
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_max = settings[s];

      lim       = (cur_max < dfr_pkg::MAX_PAYLOAD) ? {16'h0000, cur_max} :
                                                     dfr_pkg::MAX_PAYLOAD;
      small_len = (lim < 32'd16) ? lim : 32'd16;

      // lengths just past the limit, and right at it for small limits or 0xFFFF
      if (lim <= 32'd64 || cur_max == 16'hFFFF) queue_random_frame(lim, 1'b1, 1'b0);
      queue_random_frame(lim + 32'd1, 1'b0, 1'b0);
      send_queued();

      target = bytes_sent + RAND_BYTES_PER_SETTING;
      while (bytes_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          drain_results();
        end else if (pick < 10) begin
          // line noise biased toward magic prefixes
          n = $urandom_range(1, 6);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0: tx_bytes.push_back(dfr_pkg::MAGIC_0);
              1: tx_bytes.push_back(dfr_pkg::MAGIC_1);
              2: tx_bytes.push_back(dfr_pkg::MAGIC_2);
              default: tx_bytes.push_back(8'($urandom));
            endcase
          end
        end else if (pick < 16) begin
          // frame cut short, the next bytes land in its fields
          queue_random_frame($urandom_range(0, small_len), 1'b1, 1'b0);
          n = $urandom_range(1, 20);
          repeat (n) void'(tx_bytes.pop_back());
        end else if (pick < 26) begin
          // oversized length, header only
          if ($urandom_range(0, 1) == 0) begin
            len = lim + 32'd1 + 32'($urandom_range(0, 3));
          end else begin
            len = $urandom;
            if (len <= lim) len = lim + 32'd1;
          end
          queue_random_frame(len, 1'b0, 1'b0);
        end else if (pick < 36) begin
          queue_random_frame($urandom_range(0, small_len), 1'b1, 1'b1);
        end else begin
          queue_random_frame($urandom_range(0, small_len), 1'b1, 1'b0);
        end
        send_queued();
      end
    end

    drain_results();

    $display("run covered %0d bytes over %0d max_payload settings, %0d result beats checked",
             bytes_sent, NUM_SETTINGS + 1, beats_cnt);
    $display("frame ends seen: %0d good, %0d check mismatch, %0d over length",
             good_cnt, bad_cnt, long_cnt);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
